@@ hdl/astok_pkg.sv @@
// ----------------------------------------------------------------------------
// astok_pkg
// Shared types, token class codes and character helpers for the assembler
// source tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package astok_pkg;

  // Result field widths, head buffer depth and default position counter width
  localparam int unsigned FIELD_W            = 24;
  localparam int unsigned CLASS_W            = 6;
  localparam int unsigned HEAD_DEPTH         = 6;
  localparam int unsigned POSITION_WIDTH_DEF = 24;

  localparam logic [FIELD_W-1:0] FIELD_MAX = '1;

  // Control characters
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_LOW_X  = 8'h78;

  // Lexer modes
  typedef enum logic [3:0] {
    MODE_NONE    = 4'd0,
    MODE_WORD    = 4'd1,
    MODE_SYMBOL  = 4'd2,
    MODE_SLASH   = 4'd3,
    MODE_COMMENT = 4'd4,
    MODE_WS      = 4'd5,
    MODE_DEC     = 4'd6,
    MODE_HEX     = 4'd7,
    MODE_CHAR    = 4'd8,
    MODE_STRING  = 4'd9,
    MODE_QEND    = 4'd10
  } lex_mode_e;

  // Token classes
  localparam logic [CLASS_W-1:0] CLS_REG_A     = 6'd0;
  localparam logic [CLASS_W-1:0] CLS_REG_B     = 6'd1;
  localparam logic [CLASS_W-1:0] CLS_REG_C     = 6'd2;
  localparam logic [CLASS_W-1:0] CLS_REG_D     = 6'd3;
  localparam logic [CLASS_W-1:0] CLS_REG_X     = 6'd4;
  localparam logic [CLASS_W-1:0] CLS_REG_Y     = 6'd5;
  localparam logic [CLASS_W-1:0] CLS_REG_AL    = 6'd6;
  localparam logic [CLASS_W-1:0] CLS_REG_BL    = 6'd7;
  localparam logic [CLASS_W-1:0] CLS_REG_CL    = 6'd8;
  localparam logic [CLASS_W-1:0] CLS_REG_DL    = 6'd9;
  localparam logic [CLASS_W-1:0] CLS_REG_AH    = 6'd10;
  localparam logic [CLASS_W-1:0] CLS_REG_BH    = 6'd11;
  localparam logic [CLASS_W-1:0] CLS_REG_CH    = 6'd12;
  localparam logic [CLASS_W-1:0] CLS_REG_DH    = 6'd13;
  localparam logic [CLASS_W-1:0] CLS_REG_SP    = 6'd14;
  localparam logic [CLASS_W-1:0] CLS_REG_IP    = 6'd15;
  localparam logic [CLASS_W-1:0] CLS_REG_XY    = 6'd16;
  localparam logic [CLASS_W-1:0] CLS_KW_IF     = 6'd17;
  localparam logic [CLASS_W-1:0] CLS_KW_POP    = 6'd18;
  localparam logic [CLASS_W-1:0] CLS_KW_GOTO   = 6'd19;
  localparam logic [CLASS_W-1:0] CLS_KW_PUSH   = 6'd20;
  localparam logic [CLASS_W-1:0] CLS_KW_RETURN = 6'd21;
  localparam logic [CLASS_W-1:0] CLS_KW_USING  = 6'd22;
  localparam logic [CLASS_W-1:0] CLS_IDENT     = 6'd23;
  localparam logic [CLASS_W-1:0] CLS_SEMI      = 6'd24;
  localparam logic [CLASS_W-1:0] CLS_LPAREN    = 6'd25;
  localparam logic [CLASS_W-1:0] CLS_RPAREN    = 6'd26;
  localparam logic [CLASS_W-1:0] CLS_LBRACK    = 6'd27;
  localparam logic [CLASS_W-1:0] CLS_RBRACK    = 6'd28;
  localparam logic [CLASS_W-1:0] CLS_LBRACE    = 6'd29;
  localparam logic [CLASS_W-1:0] CLS_RBRACE    = 6'd30;
  localparam logic [CLASS_W-1:0] CLS_LT        = 6'd31;
  localparam logic [CLASS_W-1:0] CLS_GT        = 6'd32;
  localparam logic [CLASS_W-1:0] CLS_ASSIGN    = 6'd33;
  localparam logic [CLASS_W-1:0] CLS_COLON     = 6'd34;
  localparam logic [CLASS_W-1:0] CLS_COMMA     = 6'd35;
  localparam logic [CLASS_W-1:0] CLS_DOT       = 6'd36;
  localparam logic [CLASS_W-1:0] CLS_INC       = 6'd37;
  localparam logic [CLASS_W-1:0] CLS_DECR      = 6'd38;
  localparam logic [CLASS_W-1:0] CLS_LE        = 6'd39;
  localparam logic [CLASS_W-1:0] CLS_GE        = 6'd40;
  localparam logic [CLASS_W-1:0] CLS_ADD_EQ    = 6'd41;
  localparam logic [CLASS_W-1:0] CLS_SUB_EQ    = 6'd42;
  localparam logic [CLASS_W-1:0] CLS_MUL_EQ    = 6'd43;
  localparam logic [CLASS_W-1:0] CLS_DIV_EQ    = 6'd44;
  localparam logic [CLASS_W-1:0] CLS_MOD_EQ    = 6'd45;
  localparam logic [CLASS_W-1:0] CLS_AND_EQ    = 6'd46;
  localparam logic [CLASS_W-1:0] CLS_OR_EQ     = 6'd47;
  localparam logic [CLASS_W-1:0] CLS_XOR_EQ    = 6'd48;
  localparam logic [CLASS_W-1:0] CLS_INTEGER   = 6'd49;
  localparam logic [CLASS_W-1:0] CLS_CHARACTER = 6'd50;
  localparam logic [CLASS_W-1:0] CLS_STRING    = 6'd51;
  localparam logic [CLASS_W-1:0] CLS_INVALID   = 6'd52;

  // Head buffer: entry 0 is the first byte of the token
  typedef logic [HEAD_DEPTH-1:0][7:0] head_t;

  typedef struct packed {
    logic [CLASS_W-1:0] cls;
    logic [FIELD_W-1:0] offset;
    logic [FIELD_W-1:0] length;
  } token_t;

  // Up to two tokens closed by one source byte, in order
  typedef struct packed {
    logic   first_vld;
    logic   second_vld;
    token_t first;
    token_t second;
  } lex_emit_t;

  typedef struct packed {
    token_t tok;
    logic   last;
  } slot_t;

  function automatic logic is_sym(input logic [7:0] c);
    logic r;
    case (c)
      ";", ":", "(", ")", "{", "}", "[", "]", "<", ">", ".", ",",
      "=", "+", "-", "*", "/", "%", "&", "|", "!", "^": r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_CR) || (c == CH_SPACE) || (c == CH_LF) || (c == CH_TAB);
  endfunction

  function automatic logic is_dec(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_dec(c) || ((c >= "A") && (c <= "F")) || ((c >= "a") && (c <= "f"));
  endfunction

  // Fill count saturates at seven, meaning more than six bytes
  function automatic logic [2:0] cnt_inc(input logic [2:0] n);
    return (n == 3'd7) ? n : n + 3'd1;
  endfunction

  function automatic logic [CLASS_W-1:0] classify_word(input head_t h,
                                                       input logic [2:0] n);
    logic [CLASS_W-1:0] cls;
    cls = CLS_IDENT;
    if (n == 3'd1) begin
      case (h[0])
        "A":     cls = CLS_REG_A;
        "B":     cls = CLS_REG_B;
        "C":     cls = CLS_REG_C;
        "D":     cls = CLS_REG_D;
        "X":     cls = CLS_REG_X;
        "Y":     cls = CLS_REG_Y;
        default: cls = CLS_IDENT;
      endcase
    end else if (n == 3'd2) begin
      case ({h[0], h[1]})
        "AL":    cls = CLS_REG_AL;
        "BL":    cls = CLS_REG_BL;
        "CL":    cls = CLS_REG_CL;
        "DL":    cls = CLS_REG_DL;
        "AH":    cls = CLS_REG_AH;
        "BH":    cls = CLS_REG_BH;
        "CH":    cls = CLS_REG_CH;
        "DH":    cls = CLS_REG_DH;
        "SP":    cls = CLS_REG_SP;
        "IP":    cls = CLS_REG_IP;
        "XY":    cls = CLS_REG_XY;
        "if":    cls = CLS_KW_IF;
        default: cls = CLS_IDENT;
      endcase
    end else if (n == 3'd3) begin
      if ({h[0], h[1], h[2]} == "pop") cls = CLS_KW_POP;
    end else if (n == 3'd4) begin
      if ({h[0], h[1], h[2], h[3]} == "goto") cls = CLS_KW_GOTO;
      else if ({h[0], h[1], h[2], h[3]} == "push") cls = CLS_KW_PUSH;
    end else if (n == 3'd5) begin
      if ({h[0], h[1], h[2], h[3], h[4]} == "using") cls = CLS_KW_USING;
    end else if (n == 3'd6) begin
      if ({h[0], h[1], h[2], h[3], h[4], h[5]} == "return") cls = CLS_KW_RETURN;
    end
    return cls;
  endfunction

  function automatic logic [CLASS_W-1:0] classify_symbol(input head_t h,
                                                         input logic [2:0] n);
    logic [CLASS_W-1:0] cls;
    cls = CLS_INVALID;
    if (n == 3'd1) begin
      case (h[0])
        ";":     cls = CLS_SEMI;
        "(":     cls = CLS_LPAREN;
        ")":     cls = CLS_RPAREN;
        "[":     cls = CLS_LBRACK;
        "]":     cls = CLS_RBRACK;
        "{":     cls = CLS_LBRACE;
        "}":     cls = CLS_RBRACE;
        "<":     cls = CLS_LT;
        ">":     cls = CLS_GT;
        "=":     cls = CLS_ASSIGN;
        ":":     cls = CLS_COLON;
        ",":     cls = CLS_COMMA;
        ".":     cls = CLS_DOT;
        default: cls = CLS_INVALID;
      endcase
    end else if (n == 3'd2) begin
      if ({h[0], h[1]} == "++") begin
        cls = CLS_INC;
      end else if ({h[0], h[1]} == "--") begin
        cls = CLS_DECR;
      end else if (h[1] == "=") begin
        case (h[0])
          "<":     cls = CLS_LE;
          ">":     cls = CLS_GE;
          "+":     cls = CLS_ADD_EQ;
          "-":     cls = CLS_SUB_EQ;
          "*":     cls = CLS_MUL_EQ;
          "/":     cls = CLS_DIV_EQ;
          "%":     cls = CLS_MOD_EQ;
          "&":     cls = CLS_AND_EQ;
          "|":     cls = CLS_OR_EQ;
          "^":     cls = CLS_XOR_EQ;
          default: cls = CLS_INVALID;
        endcase
      end
    end
    return cls;
  endfunction

  // Class of the pending token, from the mode that produced it
  function automatic logic [CLASS_W-1:0] classify(input lex_mode_e m, input head_t h,
                                                  input logic [2:0] n);
    logic [CLASS_W-1:0] cls;
    unique case (m)
      MODE_WORD:           cls = classify_word(h, n);
      MODE_SYMBOL:         cls = classify_symbol(h, n);
      MODE_DEC, MODE_HEX:  cls = CLS_INTEGER;
      MODE_CHAR:           cls = CLS_CHARACTER;
      MODE_STRING:         cls = CLS_STRING;
      default:             cls = CLS_INVALID;
    endcase
    return cls;
  endfunction

endpackage

`default_nettype wire

@@ hdl/astok_lexer.sv @@
// ----------------------------------------------------------------------------
// astok_lexer
// Lexer mode machine: consumes one registered source byte per fire, updates
// mode, positions and head buffer, and closes up to two tokens.
// ----------------------------------------------------------------------------
`default_nettype none

module astok_lexer #(
  parameter int unsigned POSITION_WIDTH = astok_pkg::POSITION_WIDTH_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                fire_i,
  input  wire logic [7:0]          char_i,
  input  wire logic                eos_i,
  output astok_pkg::lex_emit_t     emit_o
);
  import astok_pkg::*;

  localparam int unsigned EXT_W = (POSITION_WIDTH > FIELD_W) ? POSITION_WIDTH : FIELD_W;
  localparam logic [POSITION_WIDTH-1:0] POS_ONE = POSITION_WIDTH'(1);
  localparam logic [POSITION_WIDTH-1:0] POS_MAX = '1;

  function automatic logic [POSITION_WIDTH-1:0] sat_inc(
      input logic [POSITION_WIDTH-1:0] v);
    return (v == POS_MAX) ? v : v + POS_ONE;
  endfunction

  function automatic logic [FIELD_W-1:0] cap_field(input logic [POSITION_WIDTH-1:0] v);
    logic [EXT_W-1:0] ext;
    ext = EXT_W'(v);
    return (ext > EXT_W'(FIELD_MAX)) ? FIELD_MAX : FIELD_W'(ext);
  endfunction

  function automatic token_t make_token(input logic [CLASS_W-1:0] cls,
                                        input logic [POSITION_WIDTH-1:0] start,
                                        input logic [POSITION_WIDTH-1:0] stop);
    token_t                    tok;
    logic [POSITION_WIDTH-1:0] len;
    len        = (stop > start) ? stop - start : POS_ONE;
    tok.cls    = cls;
    tok.offset = cap_field(start);
    tok.length = cap_field(len);
    return tok;
  endfunction

  lex_mode_e                 mode_q, mode_d, mode_v;
  logic [POSITION_WIDTH-1:0] pos_q, pos_d;
  logic [POSITION_WIDTH-1:0] ts_q, ts_d, ts_v;
  logic [2:0]                cnt_q, cnt_d, cnt_v;
  head_t                     head_q, head_d;
  logic                      go_none, go_sym;
  logic                      push_v;
  logic [2:0]                push_idx_v;
  logic                      e1_vld, e2_vld;
  logic                      is_quote;

  // Work through one byte: current mode, then a restart from none mode,
  // then the symbol mode that a symbol byte enters from none
  always_comb begin
    mode_v     = mode_q;
    ts_v       = ts_q;
    cnt_v      = cnt_q;
    go_none    = 1'b0;
    go_sym     = 1'b0;
    push_v     = 1'b0;
    push_idx_v = cnt_q;
    e1_vld     = 1'b0;
    is_quote   = (char_i == CH_SQUOTE) || (char_i == CH_DQUOTE);

    unique case (mode_q)
      MODE_NONE: begin
        go_none = 1'b1;
      end
      MODE_WORD: begin
        if (is_sym(char_i) || is_ws(char_i) || is_dec(char_i) || is_quote) begin
          e1_vld  = 1'b1;
          ts_v    = pos_q;
          cnt_v   = 3'd0;
          go_none = 1'b1;
        end else begin
          push_v = 1'b1; push_idx_v = cnt_v; cnt_v = cnt_inc(cnt_v);
        end
      end
      MODE_SYMBOL: begin
        if (is_sym(char_i)) begin
          if (char_i == CH_PLUS || char_i == CH_MINUS || char_i == CH_EQUAL) begin
            push_v = 1'b1; push_idx_v = cnt_v; cnt_v = cnt_inc(cnt_v);
          end else if (char_i == CH_SLASH) begin
            mode_v = MODE_SLASH;
            push_v = 1'b1; push_idx_v = cnt_v; cnt_v = cnt_inc(cnt_v);
          end else begin
            e1_vld = (cnt_q != 3'd0);
            ts_v   = pos_q;
            push_v = 1'b1; push_idx_v = 3'd0; cnt_v = 3'd1;
          end
        end else begin
          e1_vld  = (cnt_q != 3'd0);
          ts_v    = pos_q;
          cnt_v   = 3'd0;
          go_none = 1'b1;
        end
      end
      MODE_SLASH: begin
        if (char_i == CH_SLASH) begin
          mode_v = MODE_COMMENT;
          push_v = 1'b1; push_idx_v = cnt_v; cnt_v = cnt_inc(cnt_v);
        end else if (char_i == CH_EQUAL) begin
          push_v = 1'b1; push_idx_v = cnt_v; cnt_v = cnt_inc(cnt_v);
        end else begin
          e1_vld  = 1'b1;
          ts_v    = pos_q;
          cnt_v   = 3'd0;
          go_none = 1'b1;
        end
      end
      MODE_COMMENT: begin
        if (char_i == CH_CR || char_i == CH_LF) mode_v = MODE_WS;
      end
      MODE_WS: begin
        if (!is_ws(char_i)) begin
          ts_v    = pos_q;
          cnt_v   = 3'd0;
          go_none = 1'b1;
        end
      end
      MODE_DEC: begin
        if (char_i == CH_LOW_X) begin
          mode_v = MODE_HEX;
          push_v = 1'b1; push_idx_v = cnt_v; cnt_v = cnt_inc(cnt_v);
        end else if (is_dec(char_i)) begin
          push_v = 1'b1; push_idx_v = cnt_v; cnt_v = cnt_inc(cnt_v);
        end else begin
          e1_vld  = 1'b1;
          ts_v    = pos_q;
          cnt_v   = 3'd0;
          go_none = 1'b1;
        end
      end
      MODE_HEX: begin
        if (is_hex(char_i)) begin
          push_v = 1'b1; push_idx_v = cnt_v; cnt_v = cnt_inc(cnt_v);
        end else begin
          e1_vld  = 1'b1;
          ts_v    = pos_q;
          cnt_v   = 3'd0;
          go_none = 1'b1;
        end
      end
      MODE_CHAR, MODE_STRING: begin
        if (char_i == ((mode_q == MODE_CHAR) ? CH_SQUOTE : CH_DQUOTE)) begin
          e1_vld = (cnt_q != 3'd0);
          ts_v   = pos_q;
          cnt_v  = 3'd0;
          mode_v = MODE_QEND;
        end else begin
          push_v = 1'b1; push_idx_v = cnt_v; cnt_v = cnt_inc(cnt_v);
        end
      end
      default: begin
        // Quote end and unused codes: restart
        ts_v    = pos_q;
        cnt_v   = 3'd0;
        go_none = 1'b1;
      end
    endcase

    // Restart from none mode
    if (go_none) begin
      mode_v = MODE_NONE;
      if (is_sym(char_i)) begin
        mode_v = MODE_SYMBOL;
        go_sym = 1'b1;
      end else if (is_ws(char_i)) begin
        mode_v = MODE_WS;
      end else if (is_dec(char_i)) begin
        mode_v = MODE_DEC;
        push_v = 1'b1; push_idx_v = cnt_v; cnt_v = cnt_inc(cnt_v);
      end else if (is_quote) begin
        mode_v = (char_i == CH_SQUOTE) ? MODE_CHAR : MODE_STRING;
        ts_v   = sat_inc(pos_q);
        cnt_v  = 3'd0;
      end else begin
        mode_v = MODE_WORD;
        push_v = 1'b1; push_idx_v = cnt_v; cnt_v = cnt_inc(cnt_v);
      end
    end

    // Symbol entered from none mode: the head is empty, so nothing closes here
    if (go_sym) begin
      if (char_i == CH_SLASH) begin
        mode_v = MODE_SLASH;
      end else if (char_i != CH_PLUS && char_i != CH_MINUS && char_i != CH_EQUAL) begin
        ts_v = pos_q;
      end
      push_v = 1'b1; push_idx_v = 3'd0; cnt_v = 3'd1;
    end
  end

  // Write the pushed byte into the head buffer
  always_comb begin
    for (int i = 0; i < HEAD_DEPTH; i++) begin
      head_d[i] = (push_v && push_idx_v == 3'(i)) ? char_i : head_q[i];
    end
  end

  // Close the pending token at end of source
  always_comb begin
    e2_vld = eos_i && (cnt_v != 3'd0) &&
             (mode_v == MODE_WORD || mode_v == MODE_SYMBOL || mode_v == MODE_SLASH ||
              mode_v == MODE_DEC  || mode_v == MODE_HEX    || mode_v == MODE_CHAR  ||
              mode_v == MODE_STRING);
    emit_o.first_vld  = e1_vld;
    emit_o.first      = make_token(classify(mode_q, head_q, cnt_q), ts_q, pos_q);
    emit_o.second_vld = e2_vld;
    emit_o.second     = make_token(classify(mode_v, head_d, cnt_v), ts_v, sat_inc(pos_q));
  end

  // Next state: end of source returns to reset state
  always_comb begin
    if (eos_i) begin
      mode_d = MODE_NONE;
      pos_d  = '0;
      ts_d   = '0;
      cnt_d  = 3'd0;
    end else begin
      mode_d = mode_v;
      pos_d  = sat_inc(pos_q);
      ts_d   = ts_v;
      cnt_d  = cnt_v;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_NONE;
      pos_q  <= '0;
      ts_q   <= '0;
      cnt_q  <= 3'd0;
    end else if (fire_i) begin
      mode_q <= mode_d;
      pos_q  <= pos_d;
      ts_q   <= ts_d;
      cnt_q  <= cnt_d;
    end
  end

  // Head bytes are read only below the fill count
  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      head_q <= head_d;
    end
  end

endmodule

`default_nettype wire

@@ hdl/astok_result_buf.sv @@
// ----------------------------------------------------------------------------
// astok_result_buf
// Two-slot result register: holds the tokens closed by one byte and hands
// them out one beat at a time, first token first.
// ----------------------------------------------------------------------------
`default_nettype none

module astok_result_buf (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire astok_pkg::lex_emit_t emit_i,
  input  wire logic                 load_i,
  output logic                      ready_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output astok_pkg::slot_t          out_slot_o
);
  import astok_pkg::*;

  logic [1:0] cnt_q, cnt_d;
  slot_t      slot0_q, slot0_d;
  slot_t      slot1_q, slot1_d;
  logic       pop;

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_slot_o  = slot0_q;
  assign pop         = out_valid_o && out_ready_i;
  // Room for a new byte once the buffer is empty or drains this cycle
  assign ready_o     = (cnt_q == 2'd0) || (cnt_q == 2'd1 && pop);

  // Load new tokens, or advance the second slot on a beat
  always_comb begin
    cnt_d   = cnt_q;
    slot0_d = slot0_q;
    slot1_d = slot1_q;
    if (load_i && emit_i.first_vld && emit_i.second_vld) begin
      cnt_d   = 2'd2;
      slot0_d = '{tok: emit_i.first,  last: 1'b0};
      slot1_d = '{tok: emit_i.second, last: 1'b1};
    end else if (load_i && (emit_i.first_vld || emit_i.second_vld)) begin
      cnt_d   = 2'd1;
      slot0_d = '{tok: emit_i.first_vld ? emit_i.first : emit_i.second, last: 1'b1};
    end else if (pop) begin
      cnt_d   = cnt_q - 2'd1;
      slot0_d = slot1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

`ifndef SYNTH
  a_load_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> (cnt_q == 2'd0 || (cnt_q == 2'd1 && out_ready_i)))
    else $error("result buffer loaded while holding an unsent token");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("result buffer count out of range");

  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd2 |-> (!slot0_q.last && slot1_q.last))
    else $error("token pair not ordered first then last");

  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd1 |-> slot0_q.last)
    else $error("lone token not marked last of run");

  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !slot0_q.last) |=> out_valid_o)
    else $error("run ended without its last token");
`endif

endmodule

`default_nettype wire

@@ hdl/assembler_source_tokenizer_unit.sv @@
// ----------------------------------------------------------------------------
// assembler_source_tokenizer_unit
// Assembler source tokenizer: one source byte in per beat, tokens out as
// offset, length and class.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one source byte per beat and
//   an end_of_source flag on the final byte of a source. Output channel
//   (out_valid_o/out_ready_i) carries one token per beat; last_of_run_o marks
//   the last token caused by one input byte.
//   A byte is captured in the input register, runs through the lexer when the
//   result register has room, and its tokens are offered from that register.
//   Throughput: one byte per cycle while the receiver is ready and each byte
//   closes at most one token. A byte that closes two tokens (a token then the
//   final token at end of source) holds the input register while the two-slot
//   result register drains.
//   A stalled receiver fills the result register and then the input
//   register; nothing is dropped, and bytes resume at full rate on release.
//   Reset puts the lexer in none mode with offsets at zero and empties both
//   registers. After an end_of_source byte the lexer returns to that state.
// ----------------------------------------------------------------------------
`default_nettype none

module assembler_source_tokenizer_unit #(
  parameter int unsigned POSITION_WIDTH = astok_pkg::POSITION_WIDTH_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic [7:0]                          char_code_i,
  input  wire logic                                end_of_source_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic [astok_pkg::CLASS_W-1:0]            token_class_o,
  output logic [astok_pkg::FIELD_W-1:0]            token_offset_o,
  output logic [astok_pkg::FIELD_W-1:0]            token_length_o,
  output logic                                     last_of_run_o
);
  import astok_pkg::*;

  logic       in_vld_q;
  logic [7:0] char_q;
  logic       eos_q;
  logic       fire;
  logic       buf_ready;
  lex_emit_t  emit;
  slot_t      out_slot;

  // Process the held byte when the result register has room
  assign fire       = in_vld_q && buf_ready;
  assign in_ready_o = !in_vld_q || fire;

  // Input register: hold the byte until the lexer takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_vld_q <= 1'b1;
    end else if (fire) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      char_q <= char_code_i;
      eos_q  <= end_of_source_i;
    end
  end

  astok_lexer #(
    .POSITION_WIDTH(POSITION_WIDTH)
  ) u_lexer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .char_i (char_q),
    .eos_i  (eos_q),
    .emit_o (emit)
  );

  astok_result_buf u_result_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .emit_i      (emit),
    .load_i      (fire),
    .ready_o     (buf_ready),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_slot_o  (out_slot)
  );

  assign token_class_o  = out_slot.tok.cls;
  assign token_offset_o = out_slot.tok.offset;
  assign token_length_o = out_slot.tok.length;
  assign last_of_run_o  = out_slot.last;

endmodule

`default_nettype wire

@@ tb/assembler_source_tokenizer_unit_tb.sv @@
// ----------------------------------------------------------------------------
// assembler_source_tokenizer_unit_tb
// Self-checking bench for the source tokenizer. A behavioral lexer tracks the
// mode, positions and head bytes of the block and predicts every token beat.
// Directed sources hit word/number/quote/slash corner cases and end of source
// in most lexer modes. Random sources are built from a lexicon of registers,
// keywords and operators mixed with identifiers, numbers, quoted bodies,
// comments and noise bytes. Random back-pressure on both channels, then none.
// ----------------------------------------------------------------------------
module assembler_source_tokenizer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import astok_pkg::*;

  localparam int unsigned POS_W       = POSITION_WIDTH_DEF;
  localparam logic [POS_W-1:0] POS_TOP = '1;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned LEX_N       = 56;

  // DUT connections
  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                in_valid_i      = 1'b0;
  logic                in_ready_o;
  logic [7:0]          char_code_i     = 8'h00;
  logic                end_of_source_i = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i     = 1'b0;
  logic [CLASS_W-1:0]  token_class_o;
  logic [FIELD_W-1:0]  token_offset_o;
  logic [FIELD_W-1:0]  token_length_o;
  logic                last_of_run_o;

  // Bench state
  int unsigned snd_idle_pct = 0;
  int unsigned rcv_idle_pct = 0;
  int unsigned sent_cnt     = 0;
  int unsigned err_cnt      = 0;
  int unsigned cycle_cnt    = 0;
  slot_t       pending_tokens [$];
  slot_t       got_want;
  logic [7:0]  src_q [$];

  // Lexer shadow state
  lex_mode_e        lx_mode;
  logic [POS_W-1:0] lx_pos;
  logic [POS_W-1:0] lx_start;
  logic [7:0]       lx_head [0:HEAD_DEPTH-1];
  int unsigned      lx_fill;
  slot_t            run_tok [0:1];
  int unsigned      run_n;

  string lexicon [0:LEX_N-1] = '{
    "A", "B", "C", "D", "X", "Y", "AL", "BL", "CL", "DL", "AH", "BH", "CH", "DH",
    "SP", "IP", "XY", "if", "pop", "goto", "push", "return", "using",
    ";", "(", ")", "[", "]", "{", "}", "<", ">", "=", ":", ",", ".",
    "++", "--", "<=", ">=", "+=", "-=", "*=", "/=", "%=", "&=", "|=", "^=",
    "returns", "retur", "pops", "XYZ", "EL", "!", "*", "+"
  };

  assembler_source_tokenizer_unit u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .char_code_i     (char_code_i),
    .end_of_source_i (end_of_source_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .token_class_o   (token_class_o),
    .token_offset_o  (token_offset_o),
    .token_length_o  (token_length_o),
    .last_of_run_o   (last_of_run_o)
  );

  // Free-running clock
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- lexer --

  // Return the index of c in set, or -1 when absent
  function automatic int pos_in(input string set, input logic [7:0] c);
    int i;
    for (i = 0; i < set.len(); i++) begin
      if (set[i] == c) return i;
    end
    return -1;
  endfunction

  function automatic bit sym_byte(input logic [7:0] c);
    return pos_in(";:(){}[]<>.,=+-*/%&|!^", c) >= 0;
  endfunction

  function automatic bit space_byte(input logic [7:0] c);
    return c == CH_CR || c == CH_SPACE || c == CH_LF || c == CH_TAB;
  endfunction

  function automatic bit digit_byte(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit hexdigit_byte(input logic [7:0] c);
    return digit_byte(c) || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
  endfunction

  function automatic logic [POS_W-1:0] pos_next(input logic [POS_W-1:0] v);
    return (v == POS_TOP) ? v : v + 1'b1;
  endfunction

  // Compare the whole buffered head, fill count included, against s
  function automatic bit head_matches(input string s);
    int i;
    if (lx_fill != s.len()) return 1'b0;
    for (i = 0; i < s.len(); i++) begin
      if (lx_head[i] != s[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic [CLASS_W-1:0] word_class();
    int k;
    logic [CLASS_W-1:0] cls;
    cls = CLS_IDENT;
    if (lx_fill == 1) begin
      k = pos_in("ABCDXY", lx_head[0]);
      if (k >= 0) cls = CLS_REG_A + CLASS_W'(k);
    end else if (lx_fill == 2) begin
      k = pos_in("ABCD", lx_head[0]);
      if (k >= 0 && lx_head[1] == "L") cls = CLS_REG_AL + CLASS_W'(k);
      else if (k >= 0 && lx_head[1] == "H") cls = CLS_REG_AH + CLASS_W'(k);
      else if (head_matches("SP")) cls = CLS_REG_SP;
      else if (head_matches("IP")) cls = CLS_REG_IP;
      else if (head_matches("XY")) cls = CLS_REG_XY;
      else if (head_matches("if")) cls = CLS_KW_IF;
    end else if (head_matches("pop")) begin
      cls = CLS_KW_POP;
    end else if (head_matches("goto")) begin
      cls = CLS_KW_GOTO;
    end else if (head_matches("push")) begin
      cls = CLS_KW_PUSH;
    end else if (head_matches("return")) begin
      cls = CLS_KW_RETURN;
    end else if (head_matches("using")) begin
      cls = CLS_KW_USING;
    end
    return cls;
  endfunction

  function automatic logic [CLASS_W-1:0] symbol_class();
    int k;
    logic [CLASS_W-1:0] cls;
    cls = CLS_INVALID;
    if (lx_fill == 1) begin
      k = pos_in(";()[]{}<>=:,.", lx_head[0]);
      if (k >= 0) cls = CLS_SEMI + CLASS_W'(k);
    end else if (lx_fill == 2) begin
      if (head_matches("++")) cls = CLS_INC;
      else if (head_matches("--")) cls = CLS_DECR;
      else if (lx_head[1] == CH_EQUAL) begin
        k = pos_in("<>+-*/%&|^", lx_head[0]);
        if (k >= 0) cls = CLS_LE + CLASS_W'(k);
      end
    end
    return cls;
  endfunction

  function automatic logic [CLASS_W-1:0] token_class();
    logic [CLASS_W-1:0] cls;
    case (lx_mode)
      MODE_WORD:          cls = word_class();
      MODE_SYMBOL:        cls = symbol_class();
      MODE_DEC, MODE_HEX: cls = CLS_INTEGER;
      MODE_CHAR:          cls = CLS_CHARACTER;
      MODE_STRING:        cls = CLS_STRING;
      default:            cls = CLS_INVALID;
    endcase
    return cls;
  endfunction

  task automatic push_head(input logic [7:0] c);
    if (lx_fill < HEAD_DEPTH) lx_head[lx_fill] = c;
    if (lx_fill < 7) lx_fill++;
  endtask

  // Close the pending token at end_p and restart the literal at restart_p
  task automatic close_token(input logic [POS_W-1:0] end_p, input logic [POS_W-1:0] restart_p);
    run_tok[run_n].tok.cls    = token_class();
    run_tok[run_n].tok.offset = lx_start;
    run_tok[run_n].tok.length = (end_p > lx_start) ? end_p - lx_start : POS_W'(1);
    run_tok[run_n].last       = 1'b0;
    run_n++;
    lx_start = restart_p;
    lx_fill  = 0;
  endtask

  task automatic lex_reset();
    lx_mode  = MODE_NONE;
    lx_pos   = '0;
    lx_start = '0;
    lx_fill  = 0;
  endtask

  // Advance the shadow lexer by one accepted byte and queue its tokens
  task automatic lex_predict(input logic [7:0] c, input logic eos);
    logic [POS_W-1:0] p;
    bit again;
    int unsigned i;
    p     = lx_pos;
    run_n = 0;
    again = 1'b1;
    while (again) begin
      again = 1'b0;
      case (lx_mode)
        MODE_NONE: begin
          if (sym_byte(c)) begin
            lx_mode = MODE_SYMBOL;
            again   = 1'b1;
          end else if (space_byte(c)) begin
            lx_mode = MODE_WS;
          end else if (digit_byte(c)) begin
            lx_mode = MODE_DEC;
            push_head(c);
          end else if (c == CH_SQUOTE || c == CH_DQUOTE) begin
            lx_mode  = (c == CH_SQUOTE) ? MODE_CHAR : MODE_STRING;
            lx_start = pos_next(p);
            lx_fill  = 0;
          end else begin
            lx_mode = MODE_WORD;
            push_head(c);
          end
        end
        MODE_WORD: begin
          if (sym_byte(c) || space_byte(c) || digit_byte(c) ||
              c == CH_SQUOTE || c == CH_DQUOTE) begin
            close_token(p, p);
            lx_mode = MODE_NONE;
            again   = 1'b1;
          end else begin
            push_head(c);
          end
        end
        MODE_SYMBOL: begin
          if (sym_byte(c)) begin
            if (c == CH_PLUS || c == CH_MINUS || c == CH_EQUAL) begin
              push_head(c);
            end else if (c == CH_SLASH) begin
              lx_mode = MODE_SLASH;
              push_head(c);
            end else begin
              // any other symbol opens a fresh token
              if (lx_fill > 0) close_token(p, p);
              lx_start = p;
              lx_fill  = 0;
              push_head(c);
            end
          end else begin
            if (lx_fill > 0) close_token(p, p);
            lx_start = p;
            lx_fill  = 0;
            lx_mode  = MODE_NONE;
            again    = 1'b1;
          end
        end
        MODE_SLASH: begin
          if (c == CH_SLASH) begin
            lx_mode = MODE_COMMENT;
            push_head(c);
          end else if (c == CH_EQUAL) begin
            push_head(c);
          end else begin
            close_token(p, p);
            lx_mode = MODE_NONE;
            again   = 1'b1;
          end
        end
        MODE_COMMENT: begin
          if (c == CH_CR || c == CH_LF) lx_mode = MODE_WS;
        end
        MODE_WS: begin
          if (!space_byte(c)) begin
            lx_start = p;
            lx_fill  = 0;
            lx_mode  = MODE_NONE;
            again    = 1'b1;
          end
        end
        MODE_DEC: begin
          if (c == CH_LOW_X) begin
            lx_mode = MODE_HEX;
            push_head(c);
          end else if (digit_byte(c)) begin
            push_head(c);
          end else begin
            close_token(p, p);
            lx_mode = MODE_NONE;
            again   = 1'b1;
          end
        end
        MODE_HEX: begin
          if (hexdigit_byte(c)) begin
            push_head(c);
          end else begin
            close_token(p, p);
            lx_mode = MODE_NONE;
            again   = 1'b1;
          end
        end
        MODE_CHAR, MODE_STRING: begin
          if (c == ((lx_mode == MODE_CHAR) ? CH_SQUOTE : CH_DQUOTE)) begin
            // an empty body gives no token
            if (lx_fill > 0) close_token(p, p);
            lx_start = p;
            lx_fill  = 0;
            lx_mode  = MODE_QEND;
          end else begin
            push_head(c);
          end
        end
        default: begin
          lx_start = p;
          lx_fill  = 0;
          lx_mode  = MODE_NONE;
          again    = 1'b1;
        end
      endcase
    end

    // Flush the pending token at end of source, then start over
    if (eos) begin
      if (lx_mode != MODE_NONE && lx_mode != MODE_COMMENT && lx_mode != MODE_WS &&
          lx_mode != MODE_QEND && lx_fill > 0) begin
        close_token(pos_next(p), p);
      end
      lex_reset();
    end else begin
      lx_pos = pos_next(p);
    end

    for (i = 0; i < run_n; i++) begin
      run_tok[i].last = (i == run_n - 1);
      pending_tokens.push_back(run_tok[i]);
    end
  endtask

  // ------------------------------------------------------------- checking --

  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    err_cnt++;
  endtask

  // Randomly throttle the result channel
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= rcv_idle_pct);
  end

  // Compare each result beat with the oldest expected token
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_tokens.size() == 0) begin
        note_mismatch("unexpected token class", 32'(token_class_o), 32'h0);
      end else begin
        got_want = pending_tokens.pop_front();
        if (token_class_o !== got_want.tok.cls)
          note_mismatch("token_class", 32'(token_class_o), 32'(got_want.tok.cls));
        if (token_offset_o !== got_want.tok.offset)
          note_mismatch("token_offset", 32'(token_offset_o), 32'(got_want.tok.offset));
        if (token_length_o !== got_want.tok.length)
          note_mismatch("token_length", 32'(token_length_o), 32'(got_want.tok.length));
        if (last_of_run_o !== got_want.last)
          note_mismatch("last_of_run", 32'(last_of_run_o), 32'(got_want.last));
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("[%0t] timeout after %0d cycles", $time, cycle_cnt);
    $display("== FAIL ==");
    $finish;
  end

  // -------------------------------------------------------------- driving --

  // Offer one source byte and hold it until the beat is taken
  task automatic send_byte(input logic [7:0] c, input logic eos);
    @(negedge clk_i);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i      = 1'b1;
    char_code_i     = c;
    end_of_source_i = eos;
    @(posedge clk_i);
    while (in_ready_o !== 1'b1) @(posedge clk_i);
    lex_predict(c, eos);
    sent_cnt++;
  endtask

  task automatic send_text(input string s, input bit eos_at_end);
    int i;
    for (i = 0; i < s.len(); i++) begin
      send_byte(s[i], eos_at_end && (i == s.len() - 1));
    end
  endtask

  // Hold off the sender until every expected token has come out
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_tokens.size() != 0) @(negedge clk_i);
  endtask

  function automatic logic [7:0] pick(input string set);
    return set[$urandom_range(set.len() - 1)];
  endfunction

  function automatic logic [7:0] ws_byte();
    logic [7:0] b;
    case ($urandom_range(3))
      0:       b = CH_SPACE;
      1:       b = CH_TAB;
      2:       b = CH_LF;
      default: b = CH_CR;
    endcase
    return b;
  endfunction

  task automatic add_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) src_q.push_back(s[i]);
  endtask

  // Append one random token, mostly well formed, plus an optional separator
  task automatic add_token();
    int unsigned n;
    logic [7:0] b;
    logic [7:0] quote;
    case ($urandom_range(11))
      0, 1, 2: add_text(lexicon[$urandom_range(LEX_N - 1)]);
      3: begin
        n = $urandom_range(1, 8);
        repeat (n) src_q.push_back(pick("abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_"));
      end
      4: begin
        n = $urandom_range(1, 6);
        repeat (n) src_q.push_back(pick("0123456789"));
      end
      5: begin
        src_q.push_back(pick("0123456789"));
        src_q.push_back(CH_LOW_X);
        n = $urandom_range(0, 5);
        repeat (n) src_q.push_back(pick("0123456789abcdefABCDEF"));
      end
      6, 7: begin
        quote = ($urandom_range(1) == 0) ? CH_SQUOTE : CH_DQUOTE;
        src_q.push_back(quote);
        n = $urandom_range(0, 6);
        repeat (n) begin
          b = 8'($urandom_range(255));
          if (b == quote) b = "a";
          src_q.push_back(b);
        end
        src_q.push_back(quote);
      end
      8: begin
        add_text("//");
        n = $urandom_range(0, 8);
        repeat (n) src_q.push_back(pick("abc XYZ;=/+-0x9'"));
        src_q.push_back(($urandom_range(1) == 0) ? CH_LF : CH_CR);
      end
      9: begin
        n = $urandom_range(1, 3);
        repeat (n) src_q.push_back(pick(";:(){}[]<>.,=+-*/%&|!^"));
      end
      10: begin
        n = $urandom_range(1, 3);
        repeat (n) src_q.push_back(ws_byte());
      end
      default: begin
        n = $urandom_range(1, 2);
        repeat (n) src_q.push_back(8'($urandom_range(255)));
      end
    endcase
    if ($urandom_range(9) < 6) src_q.push_back(ws_byte());
  endtask

  // ---------------------------------------------------------------- tests --

  // Word cut by a digit, symbol run extended by '=' then swallowed by '//'
  task automatic test_word_symbol_runs();
    send_text("ab3+=//z\n", 1'b0);
  endtask

  // Decimal turned hex by 'x', empty char body, string, slash token,
  // extreme byte values, and 'return' closed by end of source
  task automatic test_literals();
    send_text("12x''\"q\"/=", 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_text(" return", 1'b1);
  endtask

  // End of source in most modes; ';' after a word closes two tokens at once
  task automatic test_end_of_source();
    send_text("A", 1'b1);
    send_text("AL;", 1'b1);
    send_text("/", 1'b1);
    send_text("0x", 1'b1);
    send_text("'z", 1'b1);
    send_text("\"ab", 1'b1);
    send_text("'", 1'b1);
    send_text("//", 1'b1);
  endtask

  // Random sources, a few truncated or left open across the next one
  task automatic test_random_sources(input int unsigned n_bytes);
    int unsigned goal;
    int unsigned ntok;
    int unsigned cut;
    int unsigned i;
    bit keep_open;
    goal = sent_cnt + n_bytes;
    wait_drained();
    while (sent_cnt < goal) begin
      src_q.delete();
      ntok = $urandom_range(1, 12);
      repeat (ntok) add_token();
      if ($urandom_range(9) == 0) begin
        cut = $urandom_range(1, src_q.size());
        while (src_q.size() > cut) src_q.delete(src_q.size() - 1);
      end
      keep_open = ($urandom_range(19) == 0);
      if ($urandom_range(7) == 0) wait_drained();
      for (i = 0; i < src_q.size(); i++) begin
        send_byte(src_q[i], !keep_open && (i == src_q.size() - 1));
      end
    end
  endtask

  initial begin
    lex_reset();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    snd_idle_pct = 37;
    rcv_idle_pct = 59;
    test_word_symbol_runs();
    test_literals();
    test_end_of_source();
    test_random_sources(630);

    snd_idle_pct = 59;
    rcv_idle_pct = 37;
    test_random_sources(630);

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    test_random_sources(640);

    // Drain and let the pipeline settle
    wait_drained();
    repeat (16) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ assembler_source_tokenizer_unit.f @@
hdl/astok_pkg.sv
hdl/astok_lexer.sv
hdl/astok_result_buf.sv
hdl/assembler_source_tokenizer_unit.sv
tb/assembler_source_tokenizer_unit_tb.sv
